// ----- rtl/core/wbss_pkg.sv -----
// wbss_pkg: constants, widths and register codes for the masked byte signature scanner.
// Used by wildcard_byte_signature_scan_top and wbss_checker; depends on nothing.
package wbss_pkg;

	localparam int MAX_PATTERN = 16;  // window depth, 4..64
	localparam int OFFSET_BITS = 32;  // byte offset counter width, 16..48
	localparam int SIG_BYTES   = 16;  // signature bytes held in the config registers

	// longest signature that can actually be compared
	localparam int LEN_MAX = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;

	localparam int WIN_IDX_BITS = $clog2(MAX_PATTERN);
	localparam int FILL_BITS    = $clog2(MAX_PATTERN + 1);
	localparam int LEN_BITS     = $clog2(LEN_MAX + 1);
	localparam int START_W      = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

	localparam int OUT_OFS_BITS = 32;
	localparam int CNT_BITS     = 32;
	localparam int LEN_REG_BITS = 5;
	localparam int MASK_BITS    = 16;

	localparam int APB_ADDR_BITS = 6;
	localparam int APB_DATA_BITS = 64;

	// register index = byte address / 8
	typedef enum logic [2:0] {
		REG_PAT_LO   = 3'd0,
		REG_PAT_HI   = 3'd1,
		REG_WILDCARD = 3'd2,
		REG_LENGTH   = 3'd3,
		REG_MODE     = 3'd4
	} reg_idx_t;

	typedef logic [7:0] byte_t;

endpackage

// ----- rtl/core/wildcard_byte_signature_scan_top.sv -----
// wildcard_byte_signature_scan_top: streaming masked byte signature search with APB config.
// Depends on wbss_pkg for widths, window depth and register codes.
//
// The block takes one image byte per cycle (in_valid/in_ready) and compares the newest
// bytes against a signature of up to 16 bytes, where any byte can be a wildcard. Every
// window start is tested, including the one ending on the last byte. A result item is
// produced when a match is reported (every match with report_all=1, only the first of the
// scan with report_all=0) or when last_byte is set; start_offset is the first byte of the
// matching window, match_total counts all matches of the scan (saturating) and is zero on
// the end-of-scan item when nothing matched. After the last byte the offset, window fill,
// count and first-match flag return to zero. Throughput is one item per cycle while the
// output is not stalled; the window and stage-1 registers load when an item is accepted,
// and the masked compare and count update then load the result register as the compare
// stage advances. A stalled output holds one result while one more item waits in
// the compare stage. Configuration (64-bit APB, register i at byte 8*i) must be written
// only while the block is idle.
module wildcard_byte_signature_scan_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input items
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           image_byte,
	input  logic                                 last_byte,
	// result items
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 match_valid,
	output logic [wbss_pkg::OUT_OFS_BITS-1:0]    start_offset,
	output logic                                 end_of_scan,
	output logic [wbss_pkg::CNT_BITS-1:0]        match_total,
	// configuration
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [wbss_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [wbss_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [wbss_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);
	import wbss_pkg::*;

	// ---------------- configuration registers ----------------
	logic [63:0]              pat_lo_q;
	logic [63:0]              pat_hi_q;
	logic [MASK_BITS-1:0]     wildcard_q;
	logic [LEN_REG_BITS-1:0]  length_q;
	logic                     report_all_q;

	reg_idx_t                 reg_idx;
	logic                     cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:3]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q     <= '0;
			pat_hi_q     <= '0;
			wildcard_q   <= '0;
			length_q     <= LEN_REG_BITS'(1);
			report_all_q <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_PAT_LO:   pat_lo_q     <= pwdata[63:0];
				REG_PAT_HI:   pat_hi_q     <= pwdata[63:0];
				REG_WILDCARD: wildcard_q   <= pwdata[MASK_BITS-1:0];
				REG_LENGTH:   length_q     <= pwdata[LEN_REG_BITS-1:0];
				REG_MODE:     report_all_q <= pwdata[0];
				default:      ;  // addresses past the register list are ignored
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PAT_LO:   prdata = pat_lo_q;
			REG_PAT_HI:   prdata = pat_hi_q;
			REG_WILDCARD: prdata = APB_DATA_BITS'(wildcard_q);
			REG_LENGTH:   prdata = APB_DATA_BITS'(length_q);
			REG_MODE:     prdata = APB_DATA_BITS'(report_all_q);
			default:      prdata = '0;
		endcase
	end

	// ---------------- handshake / stage control ----------------
	logic s1_valid_q;
	logic s1_adv;     // compare stage hands its item on this cycle
	logic in_fire;
	logic out_valid_q;

	assign s1_adv   = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// ---------------- stage 0: window shift on acceptance ----------------
	// window_q always reflects the item sitting in stage 1: it only moves when a new
	// item is accepted, which is also when stage 1 is replaced.
	byte_t                    window_q [MAX_PATTERN];
	logic [FILL_BITS-1:0]     fill_q;
	logic [OFFSET_BITS-1:0]   offset_q;

	logic [FILL_BITS-1:0]     fill_inc;

	assign fill_inc = (fill_q == FILL_BITS'(MAX_PATTERN)) ? fill_q : fill_q + 1'b1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			window_q[0] <= image_byte;
			for (int i = 1; i < MAX_PATTERN; i++) begin
				window_q[i] <= window_q[i-1];
			end
		end
	end

	logic [FILL_BITS-1:0]     fill_s1;
	logic [OFFSET_BITS-1:0]   offset_s1;
	logic                     last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			offset_q   <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				// last byte closes the scan: next byte starts at offset zero, empty window
				fill_q   <= last_byte ? '0 : fill_inc;
				offset_q <= last_byte ? '0 : offset_q + 1'b1;
			end
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			fill_s1   <= fill_inc;
			offset_s1 <= offset_q;
			last_s1   <= last_byte;
		end
	end

	// ---------------- stage 1: masked compare ----------------
	logic [SIG_BYTES*8-1:0]   pattern;
	logic [LEN_REG_BITS-1:0]  len_clip;
	logic [LEN_BITS-1:0]      eff_len;
	logic                     hit;

	assign pattern = {pat_hi_q, pat_lo_q};

	always_comb begin
		if (length_q == '0) begin
			len_clip = LEN_REG_BITS'(1);
		end else if (length_q > LEN_REG_BITS'(LEN_MAX)) begin
			len_clip = LEN_REG_BITS'(LEN_MAX);
		end else begin
			len_clip = length_q;
		end
	end

	assign eff_len = len_clip[LEN_BITS-1:0];

	// signature byte k lines up with window entry len-1-k (entry 0 is newest)
	always_comb begin
		logic [WIN_IDX_BITS-1:0] idx;
		hit = (fill_s1 >= FILL_BITS'(eff_len));
		for (int k = 0; k < LEN_MAX; k++) begin
			idx = WIN_IDX_BITS'(int'(eff_len) - 1 - k);
			if (k < int'(eff_len) && !wildcard_q[k]
				&& window_q[idx] != pattern[k*8 +: 8]) begin
				hit = 1'b0;
			end
		end
	end

	logic [CNT_BITS-1:0]      count_q;
	logic                     first_found_q;
	logic [CNT_BITS-1:0]      count_next;
	logic                     report;
	logic                     produce;
	logic [OFFSET_BITS-1:0]   start_raw;
	logic [START_W-1:0]       start_wide;

	assign count_next = (hit && count_q != '1) ? count_q + 1'b1 : count_q;
	assign report     = hit && (report_all_q || !first_found_q);
	assign produce    = report || last_s1;
	assign start_raw  = offset_s1 - OFFSET_BITS'(eff_len - 1'b1);
	assign start_wide = START_W'(start_raw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			first_found_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (s1_valid_q && s1_adv) begin
				// end of scan clears the count and first-match flag after the result
				count_q       <= last_s1 ? '0 : count_next;
				first_found_q <= last_s1 ? 1'b0 : (first_found_q || report);
			end
			if (s1_adv) begin
				out_valid_q <= s1_valid_q && produce;
			end
		end
	end

	// ---------------- result register ----------------
	logic                     match_q;
	logic [OUT_OFS_BITS-1:0]  start_q;
	logic                     eos_q;
	logic [CNT_BITS-1:0]      total_q;

	always_ff @(posedge clk) begin
		if (s1_valid_q && s1_adv && produce) begin
			match_q <= report;
			start_q <= report ? start_wide[OUT_OFS_BITS-1:0] : '0;
			eos_q   <= last_s1;
			total_q <= count_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_valid  = match_q;
	assign start_offset = start_q;
	assign end_of_scan  = eos_q;
	assign match_total  = total_q;

endmodule

// ----- rtl/core/wbss_checker.sv -----
// wbss_checker: port-level assertions for wildcard_byte_signature_scan_top, plus its bind.
// Depends on wbss_pkg for port widths.
module wbss_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_ready,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  logic                                 match_valid,
	input  logic [wbss_pkg::OUT_OFS_BITS-1:0]    start_offset,
	input  logic                                 end_of_scan,
	input  logic [wbss_pkg::CNT_BITS-1:0]        match_total
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(match_valid)
			&& $stable(start_offset) && $stable(end_of_scan) && $stable(match_total))
		else $error("result changed while stalled");

	// every result is either a reported match or the end of a scan
	a_no_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_valid || end_of_scan)
		else $error("result with neither match nor end of scan");

	// a reported match is always counted
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && match_valid |-> match_total != '0)
		else $error("match reported with zero total");

	// with the output free, the input side never stalls
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind wildcard_byte_signature_scan_top wbss_checker u_wbss_checker (.*);
